// ----- hdl/emwu_pkg.sv -----
// ----------------------------------------------------------------------------
// emwu_pkg
// Shared types, constants and the exp2 root table for the expert mixture
// weight update block.
// ----------------------------------------------------------------------------
package emwu_pkg;

    localparam int NUM_SLOTS_DEF = 8;

    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 48;

    localparam logic [23:0] W_MAX = 24'hFFFFFF;
    localparam logic [39:0] S_MAX = 40'hFF_FFFF_FFFF;

    localparam logic [1:0] CFG_SLOT_COUNT = 2'd0;
    localparam logic [1:0] CFG_RATE_EXP   = 2'd1;
    localparam logic [1:0] CFG_SHARE_MIX  = 2'd2;
    localparam logic [1:0] CFG_REL_FLOOR  = 2'd3;

    localparam logic REQ_OBSERVE = 1'b0;
    localparam logic REQ_RESET   = 1'b1;

    typedef logic [15:0][31:0] root_tab_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } div_rsp_t;

    function automatic logic [63:0] isqrt64(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bit_v;
        logic [63:0] rem;
        res   = '0;
        bit_v = 64'd1 << 62;
        rem   = v;
        for (int i = 0; i < 32; i++)
        begin
            if (rem >= res + bit_v)
            begin
                rem = rem - (res + bit_v);
                res = (res >> 1) + bit_v;
            end
            else
            begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // q1.30 roots 2^(2^-k), k = 1..16
    function automatic root_tab_t build_roots();
        root_tab_t   tab;
        logic [63:0] c;
        c = 64'd2 << 30;
        for (int k = 0; k < 16; k++)
        begin
            c      = isqrt64(c << 30);
            tab[k] = c[31:0];
        end
        return tab;
    endfunction

    localparam root_tab_t ROOTS = build_roots();

endpackage

// ----- hdl/emwu_div.sv -----
// ----------------------------------------------------------------------------
// emwu_div
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
module emwu_div (
    input  logic               clk,
    input  logic               rst_n,
    input  emwu_pkg::div_req_t req,
    output emwu_pkg::div_rsp_t rsp
);

    localparam int NW = emwu_pkg::DIV_NUM_W;
    localparam int DW = emwu_pkg::DIV_DEN_W;
    localparam int CW = $clog2(NW);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] num_reg;
    logic [DW-1:0] den_reg;
    logic [DW-1:0] rem_reg;

    logic [DW:0]   shift;
    logic [DW:0]   diff;
    logic          qbit;

    always_comb
    begin
        shift = {rem_reg, num_reg[NW-1]};
        diff  = shift - {1'b0, den_reg};
        qbit  = (shift >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            num_reg  <= '0;
            den_reg  <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                num_reg  <= req.num;
                den_reg  <= req.den;
                rem_reg  <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg <= qbit ? diff[DW-1:0] : shift[DW-1:0];
                num_reg <= {num_reg[NW-2:0], qbit};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = num_reg;

endmodule

// ----- hdl/expert_mixture_weight_update.sv -----
// ----------------------------------------------------------------------------
// expert_mixture_weight_update
// Fixed share expert mixture weight bank with pooled probability output.
// ----------------------------------------------------------------------------
// Input words arrive on in_valid/in_ready, one per slot in slot order; a run
// is slot_count words long (clamped to 1..NUM_SLOTS). Each word is absorbed
// in S_ACC_ISS and S_ACC_WB (store plus one pass through the shared
// multiplier). The last word of a reset run starts a divide and a write
// sweep over the slots. The last word of an observe run starts the update:
// one pooling divide, then per taking part slot a ratio divide, 16 log
// squarings, one rate multiply, up to 16 root multiplies and the weight
// multiply, then a share divide and per taking part slot a normalising
// divide and multiply. in_ready is low outside S_IDLE, so while each word is
// absorbed and while a run end is worked on. The pooled result sits in an
// output register on out_valid/out_ready; if the receiver stalls the next run
// end waits for it, earlier words are still taken. Reset puts all weights at
// one over NUM_SLOTS and loads the register defaults.
// ----------------------------------------------------------------------------
module expert_mixture_weight_update #(
    parameter int NUM_SLOTS = emwu_pkg::NUM_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [15:0] slot_prob,
    input  logic        slot_active,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] pooled_prob
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam int NUM_W = 40 + CNT_W;
    localparam int DEN_W = 24 + CNT_W;
    localparam int TOT_W = 40 + CNT_W;
    localparam logic [23:0] W_INIT = ((2 ** 24) / NUM_SLOTS > (2 ** 24) - 1) ?
        emwu_pkg::W_MAX : 24'((2 ** 24) / NUM_SLOTS);

    typedef enum logic [4:0] {
        S_IDLE, S_ACC_ISS, S_ACC_WB,
        S_RST_DIV, S_RST_WAIT, S_RST_WR,
        S_POOL_DIV, S_POOL_WAIT, S_SLOT, S_RATIO_WAIT,
        S_LOG_INIT, S_LOG_ISS, S_LOG_WB, S_EMUL_ISS, S_EMUL_WB,
        S_EXP_STEP, S_EXP_WB, S_WMUL_ISS, S_WMUL_WB,
        S_PART_DIV, S_PART_WAIT, S_Q_SLOT, S_Q_WAIT, S_Q_MUL, S_Q_WB,
        S_EMIT
    } state_t;

    state_t state_reg;

    logic [3:0]  slot_count_reg;
    logic [15:0] rate_exp_reg;
    logic [15:0] share_mix_reg;
    logic [15:0] rel_floor_reg;

    logic [23:0] weight_reg [NUM_SLOTS];
    logic [15:0] prob_reg   [NUM_SLOTS];
    logic        active_reg [NUM_SLOTS];
    logic [39:0] scaled_reg [NUM_SLOTS];

    logic [CNT_W-1:0] slot_index_reg;
    logic [IDX_W-1:0] cur_idx_reg;
    logic [15:0]      p_reg;
    logic             a_reg;
    logic             req_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] tally_reg;
    logic [CNT_W-1:0] run_cnt_reg;
    logic [CNT_W-1:0] slot_reg;
    logic [CNT_W-1:0] nact_reg;
    logic [TOT_W-1:0] total_reg;
    logic [23:0]      wt_rst_reg;
    logic [15:0]      pooled_reg;
    logic [23:0]      ratio_reg;
    logic [31:0]      m_reg;
    logic [15:0]      frac_reg;
    logic [4:0]       lb_reg;
    logic [3:0]       step_reg;
    logic signed [21:0] logv_reg;
    logic signed [25:0] e_reg;
    logic [23:0]      part2_reg;
    logic [24:0]      q_reg;
    logic [63:0]      prod_reg;
    logic             out_valid_reg;
    logic [15:0]      out_data_reg;

    logic [CNT_W-1:0] n_eff;
    logic [IDX_W-1:0] slot_idx;
    logic             take_part;
    logic [31:0]      mul_a;
    logic [31:0]      mul_b;
    logic             in_fire;
    logic             wb_scaled;

    emwu_pkg::div_req_t div_req;
    emwu_pkg::div_rsp_t div_rsp;

    emwu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        if (slot_count_reg == 4'd0)
            n_eff = CNT_W'(1);
        else if (int'(slot_count_reg) > NUM_SLOTS)
            n_eff = CNT_W'(NUM_SLOTS);
        else
            n_eff = CNT_W'(slot_count_reg);
    end

    assign slot_idx  = slot_reg[IDX_W-1:0];
    assign take_part = active_reg[slot_idx] && (weight_reg[slot_idx] != 24'd0);
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign wb_scaled = (state_reg == S_WMUL_WB);
    assign out_valid   = out_valid_reg;
    assign pooled_prob = out_data_reg;

    // shared multiplier operand select
    logic [20:0] log_mag;
    assign log_mag = logv_reg[21] ? 21'(-logv_reg) : 21'(logv_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_ACC_ISS:
            begin
                mul_a = {8'd0, weight_reg[cur_idx_reg]};
                mul_b = {16'd0, p_reg};
            end
            S_LOG_ISS:
            begin
                mul_a = m_reg;
                mul_b = m_reg;
            end
            S_EMUL_ISS:
            begin
                mul_a = {16'd0, rate_exp_reg};
                mul_b = {11'd0, log_mag};
            end
            S_EXP_STEP:
            begin
                mul_a = m_reg;
                mul_b = emwu_pkg::ROOTS[step_reg];
            end
            S_WMUL_ISS:
            begin
                mul_a = {8'd0, weight_reg[slot_idx]};
                mul_b = m_reg;
            end
            S_Q_MUL:
            begin
                mul_a = {7'd0, q_reg};
                mul_b = {15'd0, 17'(17'd65536 - {1'b0, share_mix_reg})};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // divider requests
    always_comb
    begin
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = '0;
        case (state_reg)
            S_RST_DIV:
            begin
                div_req.start = (tally_reg != '0);
                div_req.num   = 64'd1 << 24;
                div_req.den   = 48'(tally_reg);
            end
            S_POOL_DIV:
            begin
                div_req.start = (den_reg != '0);
                div_req.num   = 64'(num_reg) + 64'(den_reg >> 1);
                div_req.den   = 48'(den_reg);
            end
            S_SLOT:
            begin
                div_req.start = (slot_reg != run_cnt_reg) && take_part
                                && (pooled_reg != 16'd0);
                div_req.num   = {32'd0, prob_reg[slot_idx], 16'd0};
                div_req.den   = 48'(pooled_reg);
            end
            S_PART_DIV:
            begin
                div_req.start = (total_reg != '0) && (nact_reg != '0);
                div_req.num   = 64'({share_mix_reg, 8'd0}) + 64'(nact_reg >> 1);
                div_req.den   = 48'(nact_reg);
            end
            S_Q_SLOT:
            begin
                div_req.start = (slot_reg != run_cnt_reg) && take_part;
                div_req.num   = {scaled_reg[slot_idx], 24'd0};
                div_req.den   = 48'(total_reg);
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // log2 normalisation
    logic [4:0]  msb_pos;
    logic [31:0] m_norm;
    always_comb
    begin
        msb_pos = '0;
        for (int i = 0; i < 24; i++)
        begin
            if (ratio_reg[i])
                msb_pos = 5'(i);
        end
        m_norm = 32'(ratio_reg) << (5'd30 - msb_pos);
    end

    // log squaring step
    logic [31:0] sq;
    logic [15:0] frac_new;
    logic signed [5:0]  log_int;
    always_comb
    begin
        sq       = prod_reg[61:30];
        frac_new = {frac_reg[14:0], sq[31]};
        log_int  = $signed({1'b0, lb_reg}) - 6'sd16;
    end

    // rate multiply result
    logic signed [37:0] ev;
    always_comb
    begin
        if (logv_reg[21])
            ev = -$signed({1'b0, prod_reg[36:0]});
        else
            ev = $signed({1'b0, prod_reg[36:0]});
    end

    // weight scaling by 2^ip
    logic signed [10:0] ipx;
    logic [10:0]        sh;
    logic [63:0]        wm;
    logic [63:0]        raw;
    logic [39:0]        scaled_val;
    always_comb
    begin
        ipx = {e_reg[25], e_reg[25:16]};
        wm  = {8'd0, prod_reg[55:0]};
        sh  = '0;
        raw = '0;
        if (ipx > 11'sd30)
        begin
            sh = 11'(ipx - 11'sd30);
            if (sh >= 11'd40)
                raw = 64'(emwu_pkg::S_MAX);
            else if (wm > (64'(emwu_pkg::S_MAX) >> sh))
                raw = 64'(emwu_pkg::S_MAX);
            else
                raw = wm << sh;
        end
        else
        begin
            sh = 11'(11'sd30 - ipx);
            if (sh >= 11'd63)
                raw = '0;
            else if (sh == 11'd0)
                raw = wm;
            else
                raw = (wm + (64'd1 << (sh - 11'd1))) >> sh;
        end
        if (raw > 64'(emwu_pkg::S_MAX))
            scaled_val = emwu_pkg::S_MAX;
        else if (raw == 64'd0)
            scaled_val = 40'd1;
        else
            scaled_val = raw[39:0];
    end

    // normalised weight
    logic [63:0] wq;
    logic [23:0] w_new;
    always_comb
    begin
        wq = ((prod_reg + 64'd32768) >> 16) + 64'(part2_reg);
        if (wq > 64'(emwu_pkg::W_MAX))
            w_new = emwu_pkg::W_MAX;
        else if (wq == 64'd0)
            w_new = 24'd1;
        else
            w_new = wq[23:0];
    end

    logic [23:0] ratio_div;
    always_comb
    begin
        if (div_rsp.quo > 64'(emwu_pkg::W_MAX))
            ratio_div = emwu_pkg::W_MAX;
        else
            ratio_div = div_rsp.quo[23:0];
        if (ratio_div == 24'd0)
            ratio_div = (rel_floor_reg == 16'd0) ? 24'd1 : 24'(rel_floor_reg);
    end

    // payload stores
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (in_fire)
        begin
            prob_reg[slot_index_reg[IDX_W-1:0]]   <= slot_prob;
            active_reg[slot_index_reg[IDX_W-1:0]] <= slot_active;
        end
        if (wb_scaled)
            scaled_reg[slot_idx] <= scaled_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            slot_count_reg <= 4'd8;
            rate_exp_reg   <= 16'd4096;
            share_mix_reg  <= 16'd0;
            rel_floor_reg  <= 16'd1;
            for (int i = 0; i < NUM_SLOTS; i++)
                weight_reg[i] <= W_INIT;
            slot_index_reg <= '0;
            cur_idx_reg    <= '0;
            p_reg          <= '0;
            a_reg          <= 1'b0;
            req_reg        <= 1'b0;
            num_reg        <= '0;
            den_reg        <= '0;
            tally_reg      <= '0;
            run_cnt_reg    <= '0;
            slot_reg       <= '0;
            nact_reg       <= '0;
            total_reg      <= '0;
            wt_rst_reg     <= '0;
            pooled_reg     <= '0;
            ratio_reg      <= '0;
            m_reg          <= '0;
            frac_reg       <= '0;
            lb_reg         <= '0;
            step_reg       <= '0;
            logv_reg       <= '0;
            e_reg          <= '0;
            part2_reg      <= '0;
            q_reg          <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    emwu_pkg::CFG_SLOT_COUNT: slot_count_reg <= cfg_data[3:0];
                    emwu_pkg::CFG_RATE_EXP:   rate_exp_reg   <= cfg_data;
                    emwu_pkg::CFG_SHARE_MIX:  share_mix_reg  <= cfg_data;
                    emwu_pkg::CFG_REL_FLOOR:  rel_floor_reg  <= cfg_data;
                    default:                  slot_count_reg <= slot_count_reg;
                endcase
            end

            if (out_valid_reg && out_ready && (state_reg != S_EMIT))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        cur_idx_reg <= slot_index_reg[IDX_W-1:0];
                        p_reg       <= slot_prob;
                        a_reg       <= slot_active;
                        req_reg     <= req_type;
                        state_reg   <= S_ACC_ISS;
                    end
                end
                S_ACC_ISS:
                begin
                    state_reg <= S_ACC_WB;
                end
                S_ACC_WB:
                begin
                    if (a_reg)
                    begin
                        tally_reg <= tally_reg + 1'b1;
                        if (weight_reg[cur_idx_reg] != 24'd0)
                        begin
                            num_reg <= num_reg + NUM_W'(prod_reg[39:0]);
                            den_reg <= den_reg + DEN_W'(weight_reg[cur_idx_reg]);
                        end
                    end
                    if (CNT_W'(cur_idx_reg) + 1'b1 < n_eff)
                    begin
                        slot_index_reg <= CNT_W'(cur_idx_reg) + 1'b1;
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        slot_index_reg <= '0;
                        run_cnt_reg    <= CNT_W'(cur_idx_reg) + 1'b1;
                        slot_reg       <= '0;
                        state_reg <= (req_reg == emwu_pkg::REQ_RESET) ? S_RST_DIV
                                                                       : S_POOL_DIV;
                    end
                end
                S_RST_DIV:
                begin
                    if (tally_reg != '0)
                        state_reg <= S_RST_WAIT;
                    else
                    begin
                        wt_rst_reg <= '0;
                        state_reg  <= S_RST_WR;
                    end
                end
                S_RST_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        wt_rst_reg <= (div_rsp.quo > 64'(emwu_pkg::W_MAX)) ?
                                      emwu_pkg::W_MAX : div_rsp.quo[23:0];
                        state_reg  <= S_RST_WR;
                    end
                end
                S_RST_WR:
                begin
                    weight_reg[slot_idx] <= active_reg[slot_idx] ? wt_rst_reg : 24'd0;
                    slot_reg <= slot_reg + 1'b1;
                    if (slot_reg + 1'b1 == run_cnt_reg)
                    begin
                        num_reg   <= '0;
                        den_reg   <= '0;
                        tally_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                S_POOL_DIV:
                begin
                    total_reg <= '0;
                    nact_reg  <= '0;
                    if (den_reg != '0)
                        state_reg <= S_POOL_WAIT;
                    else
                    begin
                        pooled_reg <= '0;
                        state_reg  <= S_SLOT;
                    end
                end
                S_POOL_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        pooled_reg <= (div_rsp.quo > 64'hFFFF) ? 16'hFFFF
                                                                : div_rsp.quo[15:0];
                        state_reg  <= S_SLOT;
                    end
                end
                S_SLOT:
                begin
                    if (slot_reg == run_cnt_reg)
                        state_reg <= S_PART_DIV;
                    else if (!take_part)
                        slot_reg <= slot_reg + 1'b1;
                    else if (pooled_reg == 16'd0)
                    begin
                        ratio_reg <= 24'd65536;
                        state_reg <= S_LOG_INIT;
                    end
                    else
                        state_reg <= S_RATIO_WAIT;
                end
                S_RATIO_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        ratio_reg <= ratio_div;
                        state_reg <= S_LOG_INIT;
                    end
                end
                S_LOG_INIT:
                begin
                    lb_reg    <= msb_pos;
                    m_reg     <= m_norm;
                    frac_reg  <= '0;
                    step_reg  <= '0;
                    state_reg <= S_LOG_ISS;
                end
                S_LOG_ISS:
                begin
                    state_reg <= S_LOG_WB;
                end
                S_LOG_WB:
                begin
                    frac_reg <= frac_new;
                    m_reg    <= sq[31] ? (sq >> 1) : sq;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 4'd15)
                    begin
                        logv_reg  <= {log_int, frac_new};
                        state_reg <= S_EMUL_ISS;
                    end
                    else
                        state_reg <= S_LOG_ISS;
                end
                S_EMUL_ISS:
                begin
                    state_reg <= S_EMUL_WB;
                end
                S_EMUL_WB:
                begin
                    e_reg     <= 26'(ev >>> 12);
                    m_reg     <= 32'd1 << 30;
                    step_reg  <= '0;
                    state_reg <= S_EXP_STEP;
                end
                S_EXP_STEP:
                begin
                    if (e_reg[4'd15 - step_reg])
                        state_reg <= S_EXP_WB;
                    else if (step_reg == 4'd15)
                        state_reg <= S_WMUL_ISS;
                    else
                        step_reg <= step_reg + 1'b1;
                end
                S_EXP_WB:
                begin
                    m_reg <= 32'((prod_reg + (64'd1 << 29)) >> 30);
                    if (step_reg == 4'd15)
                        state_reg <= S_WMUL_ISS;
                    else
                    begin
                        step_reg  <= step_reg + 1'b1;
                        state_reg <= S_EXP_STEP;
                    end
                end
                S_WMUL_ISS:
                begin
                    state_reg <= S_WMUL_WB;
                end
                S_WMUL_WB:
                begin
                    total_reg <= total_reg + TOT_W'(scaled_val);
                    nact_reg  <= nact_reg + 1'b1;
                    slot_reg  <= slot_reg + 1'b1;
                    state_reg <= S_SLOT;
                end
                S_PART_DIV:
                begin
                    slot_reg <= '0;
                    if ((total_reg != '0) && (nact_reg != '0))
                        state_reg <= S_PART_WAIT;
                    else
                        state_reg <= S_EMIT;
                end
                S_PART_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        part2_reg <= div_rsp.quo[23:0];
                        state_reg <= S_Q_SLOT;
                    end
                end
                S_Q_SLOT:
                begin
                    if (slot_reg == run_cnt_reg)
                        state_reg <= S_EMIT;
                    else if (!take_part)
                        slot_reg <= slot_reg + 1'b1;
                    else
                        state_reg <= S_Q_WAIT;
                end
                S_Q_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        q_reg     <= div_rsp.quo[24:0];
                        state_reg <= S_Q_MUL;
                    end
                end
                S_Q_MUL:
                begin
                    state_reg <= S_Q_WB;
                end
                S_Q_WB:
                begin
                    weight_reg[slot_idx] <= w_new;
                    slot_reg  <= slot_reg + 1'b1;
                    state_reg <= S_Q_SLOT;
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= pooled_reg;
                        num_reg       <= '0;
                        den_reg       <= '0;
                        tally_reg     <= '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("ready right after an accepted word");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_POOL_WAIT || state_reg == S_RATIO_WAIT ||
                          state_reg == S_PART_WAIT || state_reg == S_Q_WAIT ||
                          state_reg == S_RST_WAIT))
        else $error("divider finished with no one waiting");

    a_slot_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(slot_index_reg) < NUM_SLOTS)
        else $error("slot index out of range");

    a_emit_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && !out_valid_reg) |=> out_valid_reg)
        else $error("run end produced no result");

endmodule

// ----- test/tb_expert_mixture_weight_update.sv -----
// ----------------------------------------------------------------------------
// tb_expert_mixture_weight_update
// Self-checking bench for the fixed share expert mixture weight bank.
// A short table of runs covers the corner cases: even weights, no active
// slots, reset runs and zero probabilities. Random runs over many register
// settings follow. Each accepted word drives a bit-accurate predictor of the
// weight bank; every pooled result is compared in order. Both sides idle at
// random in phases 0-7, and the receiver once holds off to stall the input.
// ----------------------------------------------------------------------------
module tb_expert_mixture_weight_update;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS     = 8;
    localparam int SETTLE    = 2500;
    localparam int HOLD_LEN  = 4000;
    localparam int PHASES    = 12;
    localparam int PHASE_LEN = 135;

    typedef struct {
        logic        rq;
        logic [15:0] p;
        logic        a;
        logic        chk;
        logic [15:0] val;
    } row_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_we      = 1'b0;
    logic [1:0]  cfg_index   = emwu_pkg::CFG_SLOT_COUNT;
    logic [15:0] cfg_data    = '0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic        req_type    = emwu_pkg::REQ_OBSERVE;
    logic [15:0] slot_prob   = '0;
    logic        slot_active = 1'b0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [15:0] pooled_prob;

    // shadow of the bank
    longint unsigned wt [SLOTS];
    longint unsigned pr [SLOTS];
    longint unsigned sc [SLOTS];
    bit              ac [SLOTS];
    int unsigned     pos;
    int unsigned     tally;
    longint unsigned pnum;
    longint unsigned pden;
    longint unsigned cnt_reg;
    longint unsigned rate_reg;
    longint unsigned share_reg;
    longint unsigned floor_reg;

    logic [15:0] pooled_q [$];
    int          errors    = 0;
    int          idle_mode = 0;
    int          hold_req  = 0;
    int          hold_left = 0;

    row_t dir_rows [24] = '{
        '{emwu_pkg::REQ_OBSERVE, 16'h8000, 1'b1, 1'b0, 16'h0000},
        '{emwu_pkg::REQ_OBSERVE, 16'h8000, 1'b1, 1'b0, 16'h0000},
        '{emwu_pkg::REQ_OBSERVE, 16'h8000, 1'b1, 1'b0, 16'h0000},
        '{emwu_pkg::REQ_OBSERVE, 16'h8000, 1'b1, 1'b1, 16'h8000},
        '{emwu_pkg::REQ_OBSERVE, 16'hFFFF, 1'b0, 1'b0, 16'h0000},
        '{emwu_pkg::REQ_OBSERVE, 16'h0000, 1'b0, 1'b0, 16'h0000},
        '{emwu_pkg::REQ_OBSERVE, 16'h1234, 1'b0, 1'b0, 16'h0000},
        '{emwu_pkg::REQ_OBSERVE, 16'hFFFF, 1'b0, 1'b1, 16'h0000},
        '{emwu_pkg::REQ_RESET,   16'hFFFF, 1'b1, 1'b0, 16'h0000},
        '{emwu_pkg::REQ_RESET,   16'h0000, 1'b1, 1'b0, 16'h0000},
        '{emwu_pkg::REQ_RESET,   16'h5555, 1'b0, 1'b0, 16'h0000},
        '{emwu_pkg::REQ_RESET,   16'hAAAA, 1'b1, 1'b0, 16'h0000},
        '{emwu_pkg::REQ_OBSERVE, 16'h0000, 1'b1, 1'b0, 16'h0000},
        '{emwu_pkg::REQ_OBSERVE, 16'hFFFF, 1'b1, 1'b0, 16'h0000},
        '{emwu_pkg::REQ_OBSERVE, 16'h4000, 1'b1, 1'b0, 16'h0000},
        '{emwu_pkg::REQ_OBSERVE, 16'h1234, 1'b0, 1'b0, 16'h0000},
        '{emwu_pkg::REQ_RESET,   16'h0000, 1'b0, 1'b0, 16'h0000},
        '{emwu_pkg::REQ_RESET,   16'hFFFF, 1'b0, 1'b0, 16'h0000},
        '{emwu_pkg::REQ_RESET,   16'h0001, 1'b0, 1'b0, 16'h0000},
        '{emwu_pkg::REQ_RESET,   16'h8000, 1'b0, 1'b0, 16'h0000},
        '{emwu_pkg::REQ_OBSERVE, 16'hFFFF, 1'b1, 1'b0, 16'h0000},
        '{emwu_pkg::REQ_OBSERVE, 16'h0000, 1'b1, 1'b0, 16'h0000},
        '{emwu_pkg::REQ_OBSERVE, 16'h7FFF, 1'b1, 1'b0, 16'h0000},
        '{emwu_pkg::REQ_OBSERVE, 16'h0001, 1'b1, 1'b1, 16'h0000}
    };

    expert_mixture_weight_update dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .slot_prob   (slot_prob),
        .slot_active (slot_active),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pooled_prob (pooled_prob)
    );

    always #5 clk = ~clk;

    function automatic longint unsigned sqrt_floor(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint div_down(longint a, longint d);
        if (a >= 0)
            return a / d;
        return -((-a + d - 1) / d);
    endfunction

    function automatic longint log2_fix(longint unsigned x);
        int              b;
        longint unsigned m;
        longint unsigned frac;
        b    = 23;
        frac = 0;
        while (b > 0 && x[b] == 1'b0)
            b--;
        m = x << (30 - b);
        for (int k = 0; k < 16; k++)
        begin
            m    = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31))
            begin
                frac = frac | 64'd1;
                m    = m >> 1;
            end
        end
        return longint'(b - 16) * 65536 + longint'(frac);
    endfunction

    function automatic longint unsigned apply_gain(longint unsigned w, longint e);
        longint          ip;
        longint          sh;
        longint unsigned f;
        longint unsigned m;
        longint unsigned c;
        longint unsigned wm;
        longint unsigned r;
        ip = div_down(e, 65536);
        f  = $unsigned(e - ip * 65536);
        m  = 64'd1 << 30;
        c  = 64'd2 << 30;
        for (int k = 1; k <= 16; k++)
        begin
            c = sqrt_floor(c << 30);
            if (((f >> (16 - k)) & 64'd1) != 0)
                m = (m * c + (64'd1 << 29)) >> 30;
        end
        wm = w * m;
        if (ip > 30)
        begin
            sh = ip - 30;
            if (sh >= 40 || wm > (64'(emwu_pkg::S_MAX) >> sh))
                r = 64'(emwu_pkg::S_MAX);
            else
                r = wm << sh;
        end
        else
        begin
            sh = 30 - ip;
            if (sh >= 63)
                r = 0;
            else if (sh == 0)
                r = wm;
            else
                r = (wm + (64'd1 << (sh - 1))) >> sh;
        end
        if (r > 64'(emwu_pkg::S_MAX))
            r = 64'(emwu_pkg::S_MAX);
        if (r == 0)
            r = 1;
        return r;
    endfunction

    task automatic bank_reset();
        for (int i = 0; i < SLOTS; i++)
        begin
            wt[i] = 64'd16777216 / SLOTS;
            pr[i] = 0;
            sc[i] = 0;
            ac[i] = 1'b0;
        end
        pos       = 0;
        tally     = 0;
        pnum      = 0;
        pden      = 0;
        cnt_reg   = 8;
        rate_reg  = 4096;
        share_reg = 0;
        floor_reg = 1;
    endtask

    // absorb one word into the shadow bank; got is set when a result is due
    task automatic absorb_word(input logic rq, input logic [15:0] p, input logic a,
                               output bit got, output logic [15:0] pooled);
        int unsigned     n;
        int unsigned     idx;
        int unsigned     nact;
        longint unsigned pool;
        longint unsigned total;
        longint unsigned ratio;
        longint unsigned share_part;
        longint unsigned q;
        longint unsigned w;
        longint          e;
        got    = 1'b0;
        pooled = '0;
        n      = 32'(cnt_reg);
        idx    = pos;
        nact   = 0;
        pool   = 0;
        total  = 0;
        if (n == 0)
            n = 1;
        if (n > SLOTS)
            n = SLOTS;
        if (idx >= SLOTS)
            idx = SLOTS - 1;
        pr[idx] = 64'(p);
        ac[idx] = a;
        if (a)
        begin
            tally++;
            if (wt[idx] != 0)
            begin
                pnum += wt[idx] * 64'(p);
                pden += wt[idx];
            end
        end
        if (idx + 1 < n)
        begin
            pos = idx + 1;
            return;
        end
        pos = 0;
        if (rq == emwu_pkg::REQ_RESET)
        begin
            w = 0;
            if (tally != 0)
            begin
                w = 64'd16777216 / tally;
                if (w > 64'(emwu_pkg::W_MAX))
                    w = 64'(emwu_pkg::W_MAX);
            end
            for (int i = 0; i <= idx; i++)
                wt[i] = ac[i] ? w : 0;
            pnum  = 0;
            pden  = 0;
            tally = 0;
            return;
        end
        if (pden != 0)
            pool = (pnum + pden / 2) / pden;
        if (pool > 64'hFFFF)
            pool = 64'hFFFF;
        for (int i = 0; i <= idx; i++)
        begin
            if (ac[i] && wt[i] != 0)
            begin
                if (pool == 0)
                    ratio = 65536;
                else
                begin
                    ratio = (pr[i] << 16) / pool;
                    if (ratio > 64'(emwu_pkg::W_MAX))
                        ratio = 64'(emwu_pkg::W_MAX);
                end
                if (ratio == 0)
                    ratio = (floor_reg != 0) ? floor_reg : 1;
                e     = div_down(longint'(rate_reg) * log2_fix(ratio), 4096);
                sc[i] = apply_gain(wt[i], e);
                total += sc[i];
                nact++;
            end
        end
        if (total != 0 && nact != 0)
        begin
            share_part = ((share_reg << 8) + nact / 2) / nact;
            for (int i = 0; i <= idx; i++)
            begin
                if (ac[i] && wt[i] != 0)
                begin
                    q = (sc[i] << 24) / total;
                    w = ((q * (64'd65536 - share_reg) + 64'd32768) >> 16) + share_part;
                    if (w > 64'(emwu_pkg::W_MAX))
                        w = 64'(emwu_pkg::W_MAX);
                    if (w == 0)
                        w = 1;
                    wt[i] = w;
                end
            end
        end
        pnum   = 0;
        pden   = 0;
        tally  = 0;
        got    = 1'b1;
        pooled = pool[15:0];
    endtask

    // write enable stays high across back to back writes; caller drops it
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            emwu_pkg::CFG_SLOT_COUNT: cnt_reg   = 64'(val[3:0]);
            emwu_pkg::CFG_RATE_EXP:   rate_reg  = 64'(val);
            emwu_pkg::CFG_SHARE_MIX:  share_reg = 64'(val);
            default:                  floor_reg = 64'(val);
        endcase
    endtask

    task automatic send_word(input logic rq, input logic [15:0] p, input logic a,
                             input logic chk, input logic [15:0] val);
        bit          got;
        logic [15:0] pooled;
        in_valid    <= 1'b1;
        req_type    <= rq;
        slot_prob   <= p;
        slot_active <= a;
        do
            @(posedge clk);
        while (!in_ready);
        absorb_word(rq, p, a, got, pooled);
        if (got)
            pooled_q.push_back(chk ? val : pooled);
        if ((idle_mode == 0 && $urandom_range(0, 99) < 34) ||
            (idle_mode == 1 && $urandom_range(0, 99) < 83))
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain();
        while (pooled_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // result checker and receiver stalls
    always @(posedge clk)
    begin : rx
        logic [15:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pooled_q.size() == 0)
            begin
                $error("unexpected pooled_prob word %0h", pooled_prob);
                errors++;
            end
            else
            begin
                want = pooled_q.pop_front();
                if (pooled_prob !== want)
                begin
                    $error("pooled_prob expected %0h actual %0h", want, pooled_prob);
                    errors++;
                end
            end
        end
        if (hold_req != 0)
        begin
            hold_left = HOLD_LEN;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (idle_mode == 0)
            out_ready <= ($urandom_range(0, 99) >= 83);
        else if (idle_mode == 1)
            out_ready <= ($urandom_range(0, 99) >= 34);
        else
            out_ready <= 1'b1;
    end

    initial
    begin
        #50ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int          n;
        int          sent;
        logic        rq;
        logic [15:0] p;
        logic [15:0] v;
        bank_reset();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(emwu_pkg::CFG_SLOT_COUNT, 16'd4);
        cfg_we <= 1'b0;
        foreach (dir_rows[i])
            send_word(dir_rows[i].rq, dir_rows[i].p, dir_rows[i].a,
                      dir_rows[i].chk, dir_rows[i].val);
        in_valid <= 1'b0;
        drain();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            idle_mode = (ph < 4) ? 0 : (ph < 8) ? 1 : 2;
            case ($urandom_range(0, 9))
                0:       v = 16'd0;
                1:       v = 16'd15;
                2:       v = 16'd8;
                3:       v = 16'd1;
                default: v = 16'($urandom_range(1, 4));
            endcase
            if (ph == 0)
                v = 16'd8;
            write_reg(emwu_pkg::CFG_SLOT_COUNT, v);
            case ($urandom_range(0, 4))
                0:       v = 16'd0;
                1:       v = 16'hFFFF;
                2:       v = 16'd4096;
                default: v = 16'($urandom_range(0, 16384));
            endcase
            write_reg(emwu_pkg::CFG_RATE_EXP, v);
            case ($urandom_range(0, 4))
                0:       v = 16'd0;
                1:       v = 16'hFFFF;
                default: v = 16'($urandom);
            endcase
            write_reg(emwu_pkg::CFG_SHARE_MIX, v);
            case ($urandom_range(0, 4))
                0:       v = 16'd0;
                1:       v = 16'd1;
                2:       v = 16'hFFFF;
                default: v = 16'($urandom);
            endcase
            write_reg(emwu_pkg::CFG_REL_FLOOR, v);
            cfg_we <= 1'b0;

            n = int'(cnt_reg);
            if (n == 0)
                n = 1;
            if (n > SLOTS)
                n = SLOTS;
            if (ph == 5)
                hold_req = 1;
            sent = 0;
            while (sent < PHASE_LEN)
            begin
                rq = ($urandom_range(0, 99) < 20) ? emwu_pkg::REQ_RESET
                                                  : emwu_pkg::REQ_OBSERVE;
                for (int s = 0; s < n; s++)
                begin
                    case ($urandom_range(0, 9))
                        0:       p = 16'h0000;
                        1:       p = 16'hFFFF;
                        default: p = 16'($urandom);
                    endcase
                    // occasional mixed-type run
                    if ($urandom_range(0, 99) < 10)
                        send_word(~rq, p, ($urandom_range(0, 99) < 75), 1'b0, '0);
                    else
                        send_word(rq, p, ($urandom_range(0, 99) < 75), 1'b0, '0);
                    sent++;
                end
            end
            in_valid <= 1'b0;
            drain();
        end

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/emwu_pkg.sv
hdl/emwu_div.sv
hdl/expert_mixture_weight_update.sv
test/tb_expert_mixture_weight_update.sv
